[design/mlp_pkg.sv]
// ----------------------------------------------------------------------------
// mlp_pkg: shared types and constants for the linear perceptron engine
// Item types queued between the front end, the evaluation engine and the result queue.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam logic ACT_WEIGHT = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_NUM_INPUTS  = 3'd0;
    localparam logic [2:0] CFG_NUM_OUTPUTS = 3'd1;
    localparam logic [2:0] CFG_NUM_HIDDEN  = 3'd2;
    localparam logic [2:0] CFG_NEUR_HIDDEN = 3'd3;
    localparam logic [2:0] CFG_BIAS        = 3'd4;

    // work command passed from front end to engine
    typedef struct packed {
        logic        is_weight;   // weight write
        logic        is_error;    // length mismatch result
        logic [9:0]  widx;
        logic [15:0] value;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  index;
        logic        status;
        logic        last;
    } t_res;

endpackage

[design/mlp_front.sv]
// ----------------------------------------------------------------------------
// mlp_front: input classifier
// Counts samples, stores them in the input buffer, and on the final sample
// queues either an evaluate or a length-error command. Weight writes pass on.
// ----------------------------------------------------------------------------
module mlp_front #(
    parameter int MAX_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_action,
    input  logic [9:0]         i_weight_index,
    input  logic [15:0]        i_value,
    input  logic               i_last_sample,
    input  logic [4:0]         i_num_inputs,
    output logic               o_cmd_valid,
    output mlp_pkg::t_cmd      o_cmd,
    output logic               o_smp_we,
    output logic [$clog2(MAX_WIDTH)-1:0] o_smp_addr,
    output logic [15:0]        o_smp_data
);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [4:0] r_count;
    logic [4:0] n_count;
    logic       is_smp;
    logic       bad_len;

    assign is_smp = i_take && (i_action == mlp_pkg::ACT_SAMPLE);
    assign n_count = (r_count == 5'd31) ? r_count : r_count + 5'd1;
    assign bad_len = (n_count != i_num_inputs) || (32'(i_num_inputs) > MAX_WIDTH);

    // sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (is_smp) begin
            r_count <= i_last_sample ? 5'd0 : n_count;
        end
    end

    assign o_smp_we   = is_smp && (32'(r_count) < MAX_WIDTH);
    assign o_smp_addr = AW'(r_count);
    assign o_smp_data = i_value;

    // command to engine
    assign o_cmd_valid = i_take && ((i_action == mlp_pkg::ACT_WEIGHT) || i_last_sample);
    always_comb begin
        o_cmd.is_weight = (i_action == mlp_pkg::ACT_WEIGHT);
        o_cmd.is_error  = bad_len;
        o_cmd.widx      = i_weight_index;
        o_cmd.value     = i_value;
    end
endmodule

[design/mlp_cmdq.sv]
// ----------------------------------------------------------------------------
// mlp_cmdq: small command queue
// Two-entry FIFO decoupling the front end from the evaluation engine.
// ----------------------------------------------------------------------------
module mlp_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mlp_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mlp_pkg::t_cmd o_data
);
    mlp_pkg::t_cmd r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

[design/mlp_engine.sv]
// ----------------------------------------------------------------------------
// mlp_engine: evaluation engine
// Executes weight writes and runs the layer-by-layer multiply-accumulate
// pass with one shared multiplier, one weight per cycle within a neuron.
// ----------------------------------------------------------------------------
module mlp_engine #(
    parameter int MAX_WIDTH    = 16,
    parameter int MAX_HIDDEN   = 4,
    parameter int WEIGHT_DEPTH = 1024,
    parameter int FRAC_BITS    = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  mlp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_smp_we,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_smp_addr,
    input  logic [15:0]        i_smp_data,
    input  logic [4:0]         i_num_outputs,
    input  logic [2:0]         i_num_hidden,
    input  logic [4:0]         i_neur_hidden,
    input  logic [15:0]        i_bias,
    input  logic               i_res_full,
    output logic               o_res_push,
    output mlp_pkg::t_res      o_res,
    output logic               o_busy
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WAW = $clog2(WEIGHT_DEPTH);
    localparam int HW  = $clog2(MAX_HIDDEN + 2);
    localparam int ADW = $clog2((MAX_HIDDEN + 1) * MAX_WIDTH * (MAX_WIDTH + 1) + 1);
    localparam int ACW = 48;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_DRN  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [15:0] r_wmem [WEIGHT_DEPTH];
    logic [15:0] r_act  [2*MAX_WIDTH];

    logic [2:0]     r_state;
    logic [HW-1:0]  r_layer;
    logic [AW:0]    r_j;
    logic [AW:0]    r_k;
    logic [AW:0]    r_nin;
    logic           r_src;
    logic [ADW-1:0] r_addr;
    logic [HW-1:0]  r_hid;
    logic [AW:0]    r_nhid;
    logic [AW:0]    r_nout;
    logic [ACW-1:0] r_acc;
    logic [15:0]    r_w;
    logic [15:0]    r_x;
    logic           r_wzero;
    logic           r_p1v;
    logic [31:0]    r_prod;
    logic           r_p2v;

    logic [AW:0]    cur_nout;
    logic           is_last_layer;
    logic [15:0]    sat;
    logic [ACW-1:0] shifted;
    logic           w_in_range;
    logic [4:0]     cmd_nin;

    // clamp layer sizes
    function automatic logic [AW:0] clampw(input logic [4:0] n);
        if (n == 5'd0)             return (AW+1)'(1);
        if (32'(n) > MAX_WIDTH)    return (AW+1)'(MAX_WIDTH);
        return (AW+1)'(n);
    endfunction

    // evaluate commands carry the input count in the index field
    assign cmd_nin = i_cmd.widx[4:0];

    assign is_last_layer = (r_layer == r_hid);
    assign cur_nout = is_last_layer ? r_nout : r_nhid;
    assign w_in_range = (32'(r_addr) < WEIGHT_DEPTH);
    assign o_busy = (r_state != S_IDLE);

    // floor shift and saturate
    assign shifted = $signed(r_acc) >>> FRAC_BITS;
    always_comb begin
        if ($signed(shifted) > $signed(ACW'(32767)))       sat = 16'h7FFF;
        else if ($signed(shifted) < $signed(-ACW'(32768))) sat = 16'h8000;
        else                                               sat = shifted[15:0];
    end

    // weight store and activation buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_cmd_empty && i_cmd.is_weight
                && 32'(i_cmd.widx) < WEIGHT_DEPTH) begin
            r_wmem[WAW'(i_cmd.widx)] <= i_cmd.value;
        end
        if (r_state == S_MAC) begin
            r_w <= r_wmem[WAW'(r_addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp_we) begin
            r_act[{1'b0, i_smp_addr}] <= i_smp_data;
        end
        if (r_state == S_WB) begin
            r_act[{~r_src, r_j[AW-1:0]}] <= sat;
        end
        if (r_state == S_MAC) begin
            r_x <= (r_k == r_nin) ? i_bias : r_act[{r_src, r_k[AW-1:0]}];
        end
    end

    // multiply pipeline
    always_ff @(posedge i_clk) begin
        r_prod <= r_wzero ? 32'd0 : 32'($signed(r_w) * $signed(r_x));
    end

    // accumulator: cleared outside a neuron, fed from the product stage
    always_ff @(posedge i_clk) begin
        if (r_state != S_MAC && r_state != S_DRN) begin
            r_acc <= '0;
        end else if (r_p2v) begin
            r_acc <= r_acc + ACW'($signed(r_prod));
        end
    end

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty &&
                        (i_cmd.is_weight || !i_res_full);
    assign o_res_push = ((r_state == S_IDLE) && o_cmd_pop && !i_cmd.is_weight &&
                         i_cmd.is_error) ||
                        ((r_state == S_EMIT) && !i_res_full);
    always_comb begin
        if (r_state == S_IDLE) begin
            o_res = '{value: 16'd0, index: 4'd0, status: 1'b1, last: 1'b1};
        end else begin
            o_res.value  = r_act[{r_src, r_j[AW-1:0]}];
            o_res.index  = 4'(r_j);
            o_res.status = 1'b0;
            o_res.last   = (r_j + 1'b1 == r_nout);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p1v   <= 1'b0;
            r_p2v   <= 1'b0;
        end else begin
            r_p1v <= (r_state == S_MAC);
            r_p2v <= r_p1v;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && !i_cmd.is_weight && !i_cmd.is_error) begin
                        r_state <= S_MAC;
                        r_layer <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_src   <= 1'b0;
                        r_addr  <= '0;
                        r_nin   <= (AW+1)'(cmd_nin);
                        r_hid   <= (32'(i_num_hidden) > MAX_HIDDEN) ?
                                   HW'(MAX_HIDDEN) : HW'(i_num_hidden);
                        r_nhid  <= clampw(i_neur_hidden);
                        r_nout  <= clampw(i_num_outputs);
                    end
                end
                S_MAC: begin
                    r_wzero <= !w_in_range;
                    r_addr  <= r_addr + ADW'(1);
                    if (r_k == r_nin) begin
                        r_k     <= '0;
                        r_state <= S_DRN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRN: begin
                    if (!r_p1v && !r_p2v) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_j + 1'b1 == cur_nout) begin
                        r_j     <= '0;
                        r_src   <= ~r_src;
                        r_nin   <= cur_nout;
                        r_layer <= r_layer + 1'b1;
                        r_state <= is_last_layer ? S_EMIT : S_MAC;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        if (r_j + 1'b1 == r_nout) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[design/mlp_resq.sv]
// ----------------------------------------------------------------------------
// mlp_resq: result queue
// Two-entry FIFO holding results until the consumer pops them.
// ----------------------------------------------------------------------------
module mlp_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mlp_pkg::t_res i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mlp_pkg::t_res o_data
);
    mlp_pkg::t_res r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_ok};
        end
    end
endmodule

[design/mlp_linear_inference.sv]
// ----------------------------------------------------------------------------
// mlp_linear_inference: linear multilayer perceptron, Q4.12
// Top level: front end, command queue, evaluation engine, result queue.
// ----------------------------------------------------------------------------
// Weight writes and samples are taken one per cycle while no network pass is
// pending or running. The final sample of a vector queues the pass, and full
// then stays high until the engine has handed its last result to the result
// queue, so the input buffer is never overwritten under a pass. The pass runs
// on a single shared multiplier: each neuron streams its weights and the bias
// through the multiply pipeline, then drains it and writes its result back, and
// the results are then emitted one per cycle while the result queue has room. A
// length error gives its single result without a pass. Weights must be written
// before use; the user must write configuration only while idle, as the block
// itself does not enforce it.
module mlp_linear_inference #(
    parameter int MAX_WIDTH    = 16,
    parameter int MAX_HIDDEN   = 4,
    parameter int WEIGHT_DEPTH = 1024,
    parameter int FRAC_BITS    = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [9:0]  i_weight_index,
    input  logic signed [15:0] i_value,
    input  logic        i_last_sample,
    output logic        empty,
    input  logic        pop,
    output logic signed [15:0] o_output_value,
    output logic [3:0]  o_output_index,
    output logic        o_status,
    output logic        o_last_output,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [4:0]  r_num_inputs;
    logic [4:0]  r_num_outputs;
    logic [2:0]  r_num_hidden;
    logic [4:0]  r_neur_hidden;
    logic [15:0] r_bias;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_inputs  <= 5'd4;
            r_num_outputs <= 5'd2;
            r_num_hidden  <= 3'd1;
            r_neur_hidden <= 5'd8;
            r_bias        <= 16'hF000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlp_pkg::CFG_NUM_INPUTS:  r_num_inputs  <= i_cfg_data[4:0];
                mlp_pkg::CFG_NUM_OUTPUTS: r_num_outputs <= i_cfg_data[4:0];
                mlp_pkg::CFG_NUM_HIDDEN:  r_num_hidden  <= i_cfg_data[2:0];
                mlp_pkg::CFG_NEUR_HIDDEN: r_neur_hidden <= i_cfg_data[4:0];
                mlp_pkg::CFG_BIAS:        r_bias        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic          take;
    logic          cmd_valid;
    mlp_pkg::t_cmd cmd_in;
    mlp_pkg::t_cmd cmd_fw;
    mlp_pkg::t_cmd cmd_out;
    logic          cmdq_full;
    logic          cmdq_empty;
    logic          cmd_pop;
    logic          smp_we;
    logic [AW-1:0] smp_addr;
    logic [15:0]   smp_data;
    logic          res_push;
    logic          resq_full;
    logic          eng_busy;
    logic          r_vec_pend;
    mlp_pkg::t_res res_in;
    mlp_pkg::t_res res_out;

    // a queued vector command holds off input until the engine takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_pend <= 1'b0;
        end else if (cmd_valid && !cmd_fw.is_weight) begin
            r_vec_pend <= 1'b1;
        end else if (cmd_pop && !cmd_out.is_weight) begin
            r_vec_pend <= 1'b0;
        end
    end

    assign full = cmdq_full || r_vec_pend || eng_busy;
    assign take = push && !full;

    mlp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_action       (i_action),
        .i_weight_index (i_weight_index),
        .i_value        (i_value),
        .i_last_sample  (i_last_sample),
        .i_num_inputs   (r_num_inputs),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd_fw),
        .o_smp_we       (smp_we),
        .o_smp_addr     (smp_addr),
        .o_smp_data     (smp_data)
    );

    // evaluate commands carry the input count in the index field
    always_comb begin
        cmd_in = cmd_fw;
        if (!cmd_fw.is_weight) begin
            cmd_in.widx = {5'd0, r_num_inputs};
        end
    end

    mlp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_empty (cmdq_empty),
        .o_data  (cmd_out)
    );

    mlp_engine #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HIDDEN   (MAX_HIDDEN),
        .WEIGHT_DEPTH (WEIGHT_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (cmdq_empty),
        .i_cmd         (cmd_out),
        .o_cmd_pop     (cmd_pop),
        .i_smp_we      (smp_we),
        .i_smp_addr    (smp_addr),
        .i_smp_data    (smp_data),
        .i_num_outputs (r_num_outputs),
        .i_num_hidden  (r_num_hidden),
        .i_neur_hidden (r_neur_hidden),
        .i_bias        (r_bias),
        .i_res_full    (resq_full),
        .o_res_push    (res_push),
        .o_res         (res_in),
        .o_busy        (eng_busy)
    );

    mlp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_output_value = res_out.value;
    assign o_output_index = res_out.index;
    assign o_status       = res_out.status;
    assign o_last_output  = res_out.last;
endmodule

[tb/mlp_linear_inference_tb.sv]
// ----------------------------------------------------------------------------
// mlp_linear_inference_tb: self-checking bench for the linear perceptron
// Queues weight writes and sample vectors, predicts each network pass in
// Q4.12, and checks every result item in order under random push/pop gaps.
// ----------------------------------------------------------------------------
module mlp_linear_inference_tb;

    localparam int  NET_W       = 16;
    localparam int  NET_HID     = 4;
    localparam int  STORE_DEPTH = 1024;
    localparam int  CYCLE_LIMIT = 100000;

    typedef struct {
        logic        action;
        logic [9:0]  widx;
        logic [15:0] value;
        logic        last;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [9:0]  i_weight_index;
    logic signed [15:0] i_value;
    logic        i_last_sample;
    logic        empty;
    logic        pop;
    logic signed [15:0] o_output_value;
    logic [3:0]  o_output_index;
    logic        o_status;
    logic        o_last_output;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    mlp_linear_inference u_top (.*);

    // pending stimulus and expected results
    t_item         pend_items[$];
    mlp_pkg::t_res exp_results[$];

    // predictor state
    logic signed [15:0] wmem [STORE_DEPTH];
    logic signed [15:0] act_buf [2*NET_W];
    int unsigned        smp_count;
    int unsigned        p_inputs, p_outputs, p_hidden, p_neurons;
    logic signed [15:0] p_bias;

    // weights already queued for writing
    bit    planned [STORE_DEPTH];
    int    errors;
    int    cycles;
    bit    calm;
    int    push_gap;
    int    pop_gap;
    bit    took;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int unsigned clamp_w(input int unsigned n);
        if (n < 1) return 1;
        if (n > NET_W) return NET_W;
        return n;
    endfunction

    // floor shift by the fraction bits, saturated to 16 bits
    function automatic logic signed [15:0] shift_sat(input longint acc);
        longint q;
        q = acc >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // evaluate one accepted item and queue the results it causes
    task automatic predict_item(input t_item it);
        int unsigned   len, hid, nhid, nout, n_in, n_out, src, dst, adr;
        longint        acc;
        longint        w;
        mlp_pkg::t_res r;
        if (it.action == mlp_pkg::ACT_WEIGHT) begin
            wmem[it.widx] = it.value;
            return;
        end
        if (smp_count < NET_W) act_buf[smp_count] = it.value;
        if (smp_count < 31) smp_count++;
        if (!it.last) return;
        len = smp_count;
        smp_count = 0;
        if (len != p_inputs || p_inputs > NET_W) begin
            r.value = '0; r.index = '0; r.status = 1'b1; r.last = 1'b1;
            exp_results = {exp_results, r};
            return;
        end
        hid  = (p_hidden > NET_HID) ? NET_HID : p_hidden;
        nhid = clamp_w(p_neurons);
        nout = clamp_w(p_outputs);
        n_in = p_inputs;
        src  = 0;
        adr  = 0;
        for (int unsigned layer = 0; layer <= hid; layer++) begin
            n_out = (layer == hid) ? nout : nhid;
            dst = src ^ NET_W;
            for (int unsigned j = 0; j < n_out; j++) begin
                acc = 0;
                for (int unsigned k = 0; k <= n_in; k++) begin
                    w = (adr < STORE_DEPTH) ? longint'(wmem[adr]) : 0;
                    if (k < n_in) acc += w * longint'(act_buf[src + k]);
                    else acc += w * longint'(p_bias);
                    adr++;
                end
                act_buf[dst + j] = shift_sat(acc);
            end
            src = dst;
            n_in = n_out;
        end
        for (int unsigned j = 0; j < nout; j++) begin
            r.value = act_buf[src + j];
            r.index = j[3:0];
            r.status = 1'b0;
            r.last = (j + 1 == nout);
            exp_results = {exp_results, r};
        end
    endtask

    // input side: accept at rising edge, present at falling edge
    always @(posedge i_clk) begin
        took = 1'b0;
        if (i_rst_n && push && !full) begin
            predict_item(pend_items.pop_front());
            took = 1'b1;
            push_gap = calm ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !took) begin
            push <= 1'b1;
        end else if (push_gap > 0) begin
            push_gap--;
            push <= 1'b0;
        end else if (pend_items.size() > 0) begin
            i_action       <= pend_items[0].action;
            i_weight_index <= pend_items[0].widx;
            i_value        <= pend_items[0].value;
            i_last_sample  <= pend_items[0].last;
            push <= 1'b1;
        end else begin
            push <= 1'b0;
        end
    end

    // result side: compare each popped item against the oldest expectation
    always @(posedge i_clk) begin
        mlp_pkg::t_res e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && pop && !empty) begin
            pop_gap = calm ? 0 : $urandom_range(0, 3);
            if (exp_results.size() == 0) begin
                report("unexpected result", o_output_value, 0);
            end else begin
                e = exp_results.pop_front();
                if (o_output_value !== e.value)
                    report("output_value", o_output_value, $signed(e.value));
                if (o_output_index !== e.index) report("output_index", o_output_index, e.index);
                if (o_status !== e.status) report("status", o_status, e.status);
                if (o_last_output !== e.last) report("last_output", o_last_output, e.last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ---- stimulus helpers ----
    task automatic add_weight(input int idx, input logic [15:0] val, input logic lst);
        t_item it;
        it.action = mlp_pkg::ACT_WEIGHT; it.widx = idx[9:0]; it.value = val; it.last = lst;
        pend_items = {pend_items, it};
        planned[idx] = 1'b1;
    endtask

    task automatic add_sample(input logic [15:0] val, input logic lst);
        t_item it;
        it.action = mlp_pkg::ACT_SAMPLE; it.widx = 10'($urandom); it.value = val;
        it.last = lst;
        pend_items = {pend_items, it};
    endtask

    // a vector of n samples; mode 0 random, 1 all max, 2 all min
    task automatic add_vector(input int n, input int mode);
        logic [15:0] v;
        for (int k = 0; k < n; k++) begin
            v = (mode == 1) ? 16'h7fff : (mode == 2) ? 16'h8000 : 16'($urandom);
            add_sample(v, k == n - 1);
        end
    endtask

    function automatic logic [15:0] rand_weight();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    // write every weight the current shape reads that is not yet queued
    task automatic cover_weights();
        int unsigned hid, nhid, nout, total;
        if (p_inputs > NET_W) return;
        hid  = (p_hidden > NET_HID) ? NET_HID : p_hidden;
        nhid = clamp_w(p_neurons);
        nout = clamp_w(p_outputs);
        if (hid == 0) total = nout * (p_inputs + 1);
        else total = nhid * (p_inputs + 1) + (hid - 1) * nhid * (nhid + 1)
                     + nout * (nhid + 1);
        for (int a = 0; a < total && a < STORE_DEPTH; a++)
            if (!planned[a]) add_weight(a, rand_weight(), 1'($urandom_range(0, 1)));
    endtask

    // drain everything, then let trailing work settle
    task automatic wait_idle();
        while (pend_items.size() > 0 || push || exp_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mlp_pkg::CFG_NUM_INPUTS:  p_inputs  = 32'(data[4:0]);
            mlp_pkg::CFG_NUM_OUTPUTS: p_outputs = 32'(data[4:0]);
            mlp_pkg::CFG_NUM_HIDDEN:  p_hidden  = 32'(data[2:0]);
            mlp_pkg::CFG_NEUR_HIDDEN: p_neurons = 32'(data[4:0]);
            default:                  p_bias    = data;
        endcase
    endtask

    task automatic set_shape(input int ni, input int no, input int nh, input int nn,
                             input logic [15:0] b);
        cfg_write(mlp_pkg::CFG_NUM_INPUTS, 16'(ni));
        cfg_write(mlp_pkg::CFG_NUM_OUTPUTS, 16'(no));
        cfg_write(mlp_pkg::CFG_NUM_HIDDEN, 16'(nh));
        cfg_write(mlp_pkg::CFG_NEUR_HIDDEN, 16'(nn));
        cfg_write(mlp_pkg::CFG_BIAS, b);
    endtask

    // ---- test sequence ----
    initial begin
        int n;
        errors = 0; cycles = 0; calm = 1'b0; push_gap = 0; pop_gap = 0; took = 1'b0;
        smp_count = 0;
        p_inputs = 4; p_outputs = 2; p_hidden = 1; p_neurons = 8; p_bias = 16'shf000;
        i_rst_n = 1'b0; push = 1'b0; pop = 1'b0;
        i_action = mlp_pkg::ACT_WEIGHT; i_weight_index = '0; i_value = '0;
        i_last_sample = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = mlp_pkg::CFG_NUM_INPUTS; i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset shape, extreme samples, length errors, top index
        cover_weights();
        add_weight(STORE_DEPTH - 1, 16'h8000, 1'b1);
        add_weight(0, 16'h7fff, 1'b0);
        add_vector(4, 1);
        add_vector(4, 2);
        add_vector(4, 0);
        add_vector(3, 0);
        add_vector(5, 0);
        add_vector(33, 0);
        add_vector(4, 0);
        wait_idle();

        // widest output layer, no hidden layer, extreme bias
        set_shape(3, 16, 0, 8, 16'h7fff);
        cover_weights();
        add_vector(3, 1);
        add_vector(3, 0);
        wait_idle();
        cfg_write(mlp_pkg::CFG_BIAS, 16'h8000);
        add_vector(3, 2);
        add_vector(1, 0);
        wait_idle();

        // widest input vector
        set_shape(16, 1, 0, 8, 16'h1000);
        cover_weights();
        add_vector(16, 0);
        wait_idle();

        // out-of-range shape registers saturate; oversize input count errors
        set_shape(1, 0, 7, 0, 16'h0000);
        cover_weights();
        add_vector(1, 0);
        add_vector(1, 1);
        wait_idle();
        set_shape(17, 31, 3, 31, 16'hf000);
        add_vector(17, 0);
        wait_idle();

        // random phases: mostly well-formed vectors, some noise
        for (int ph = 0; ph < 5; ph++) begin
            calm = ($urandom_range(0, 3) == 0);
            set_shape($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 2),
                      $urandom_range(1, 6), 16'($urandom));
            cover_weights();
            for (int v = 0; v < 4; v++) begin
                if ($urandom_range(0, 2) == 0)
                    add_weight($urandom_range(0, STORE_DEPTH - 1), rand_weight(),
                               1'($urandom_range(0, 1)));
                case ($urandom_range(0, 7))
                    0: n = $urandom_range(1, 34);
                    1: n = p_inputs + 1;
                    default: n = p_inputs;
                endcase
                add_vector(n, 0);
            end
            add_vector(p_inputs, 0);
            wait_idle();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[mlp_linear_inference.f]
design/mlp_pkg.sv
design/mlp_front.sv
design/mlp_cmdq.sv
design/mlp_engine.sv
design/mlp_resq.sv
design/mlp_linear_inference.sv
tb/mlp_linear_inference_tb.sv
